FILE: hw/rtl/mm3_pkg.sv
// mm3_pkg: constants and controller/datapath interface types for the murmur3 hash core
// no dependencies

package mm3_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd2333;
    localparam logic [WORD_W-1:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MIX_C2     = 32'h1b873593;
    localparam logic [WORD_W-1:0] MIX_ADD    = 32'he6546b64;
    localparam logic [WORD_W-1:0] FIN_C1     = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] FIN_C2     = 32'hc2b2ae35;

    localparam int unsigned ROT_K   = 15;
    localparam int unsigned ROT_H   = 13;
    localparam int unsigned SHR_A   = 16;
    localparam int unsigned SHR_B   = 13;

    typedef struct packed {
        logic accept;
        logic scr1;
        logic scr2;
        logic word_mix;
        logic fin0;
        logic fin1;
        logic fin_load;
    } t_dp_cmd;

    typedef struct packed {
        logic lane3;
        logic out_free;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

endpackage

FILE: hw/rtl/mm3_ctrl.sv
// mm3_ctrl: sequencing state machine for the murmur3 hash core
// depends on mm3_pkg for the command and status types

module mm3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_has_byte,
    input  logic             i_last,
    output logic             o_in_ready,
    input  mm3_pkg::t_dp_sts i_sts,
    output mm3_pkg::t_dp_cmd o_cmd
);
    import mm3_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K1   = 3'd1;
    localparam logic [2:0] S_K2   = 3'd2;
    localparam logic [2:0] S_WM   = 3'd3;
    localparam logic [2:0] S_F0   = 3'd4;
    localparam logic [2:0] S_F1   = 3'd5;
    localparam logic [2:0] S_F2   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_pend_last, n_pend_last;
    logic       r_tail, n_tail;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_pend_last = r_pend_last;
        n_tail      = r_tail;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept) begin
                    if (i_has_byte && i_sts.lane3) begin
                        n_state     = S_K1;
                        n_pend_last = i_last;
                        n_tail      = 1'b0;
                    end else if (i_last) begin
                        n_state     = S_K1;
                        n_pend_last = 1'b0;
                        n_tail      = 1'b1;
                    end
                end
            end
            S_K1: begin
                o_cmd.scr1 = 1'b1;
                n_state    = S_K2;
            end
            S_K2: begin
                o_cmd.scr2 = 1'b1;
                n_state    = r_tail ? S_F0 : S_WM;
            end
            S_WM: begin
                o_cmd.word_mix = 1'b1;
                if (r_pend_last) begin
                    n_state     = S_K1;
                    n_tail      = 1'b1;
                    n_pend_last = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_F0: begin
                o_cmd.fin0 = 1'b1;
                n_state    = S_F1;
            end
            S_F1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = S_F2;
            end
            S_F2: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_last <= 1'b0;
            r_tail      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_last <= n_pend_last;
            r_tail      <= n_tail;
        end
    end

    // at most one datapath operation per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.scr1, o_cmd.scr2, o_cmd.word_mix,
                  o_cmd.fin0, o_cmd.fin1, o_cmd.fin_load}))
        else $error("more than one datapath command");

    // a full word with last runs the word mix and then the tail scramble
    a_word_then_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.word_mix && r_pend_last) |=> (r_state == S_K1 && r_tail))
        else $error("tail scramble skipped after word mix");

endmodule

FILE: hw/rtl/mm3_dp.sv
// mm3_dp: hash datapath with seed, accumulator, word buffer, length and output registers
// depends on mm3_pkg for constants, rotate function and command/status types

module mm3_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mm3_pkg::WORD_W-1:0]     i_cfg_seed,
    input  logic [mm3_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_has_byte,
    input  logic                           i_last,
    input  mm3_pkg::t_dp_cmd               i_cmd,
    output mm3_pkg::t_dp_sts               o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mm3_pkg::WORD_W-1:0]     o_hash
);
    import mm3_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_buf;
    logic [WORD_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_k;
    logic [WORD_W-1:0] r_hash;
    logic              r_busy;
    logic              r_out_valid;

    logic              start;
    logic [WORD_W-1:0] base_buf;
    logic [WORD_W-1:0] base_cnt;
    logic [WORD_W-1:0] byte_sh;
    logic [WORD_W-1:0] mix_h;
    logic [WORD_W-1:0] fin_h;
    logic [WORD_W-1:0] fin1_h;

    assign start    = i_cmd.accept && (i_has_byte || i_last) && !r_busy;
    assign base_buf = start ? '0 : r_buf;
    assign base_cnt = start ? '0 : r_cnt;
    assign byte_sh  = {{(WORD_W-BYTE_W){1'b0}}, i_data_byte} << {base_cnt[1:0], 3'b000};

    assign mix_h  = rotl(r_acc ^ r_k, ROT_H);
    assign fin_h  = (r_acc ^ r_k ^ r_cnt) ^ ((r_acc ^ r_k ^ r_cnt) >> SHR_A);
    assign fin1_h = r_k ^ (r_k >> SHR_B);

    assign o_sts.lane3    = !start && (r_cnt[1:0] == 2'd3);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= SEED_RESET;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_cmd.accept && (i_has_byte || i_last)) begin
                r_busy <= 1'b1;
                if (start) begin
                    r_acc <= r_seed;
                end
                if (i_has_byte) begin
                    r_buf <= base_buf | byte_sh;
                    r_cnt <= base_cnt + 32'd1;
                end else begin
                    r_buf <= base_buf;
                    r_cnt <= base_cnt;
                end
            end
            if (i_cmd.word_mix) begin
                r_acc <= (mix_h << 2) + mix_h + MIX_ADD;
                r_buf <= '0;
            end
            if (i_cmd.fin_load) begin
                r_acc  <= r_seed;
                r_buf  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b0;
            end
        end
    end

    // shared multiply register for scramble and finalize
    always_ff @(posedge i_clk) begin
        if (i_cmd.scr1) begin
            r_k <= r_buf * MIX_C1;
        end else if (i_cmd.scr2) begin
            r_k <= rotl(r_k, ROT_K) * MIX_C2;
        end else if (i_cmd.fin0) begin
            r_k <= fin_h * FIN_C1;
        end else if (i_cmd.fin1) begin
            r_k <= fin1_h * FIN_C2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_hash <= r_k ^ (r_k >> SHR_A);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // finishing a message clears the length and leaves a result pending
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_load |=> (r_cnt == '0 && !r_busy && r_out_valid))
        else $error("message state not cleared on finalize");

    // a word mix always empties the word buffer
    a_mix_clears_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.word_mix |=> (r_buf == '0))
        else $error("word buffer not cleared after mix");

endmodule

FILE: hw/rtl/murmur3_32_stream_hash_core.sv
// a byte transfer is accepted while idle; every fourth byte adds the word mix (scramble 1, scramble 2, mix)
// the last item adds the tail scramble and finalize (fin0, fin1, fin load) before the result shows
// one shared 32x32 multiply register sets the step count; one message at a time
// reset: seed 2333, message state cleared, no result pending
// top level: joins controller and datapath; depends on mm3_pkg, mm3_ctrl and mm3_dp

module murmur3_32_stream_hash_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mm3_pkg::WORD_W-1:0] i_cfg_seed,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [mm3_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_has_byte,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mm3_pkg::WORD_W-1:0] o_hash
);
    import mm3_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    mm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_has_byte (i_has_byte),
        .i_last     (i_last),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mm3_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_seed  (i_cfg_seed),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hash      (o_hash)
    );

endmodule

FILE: sim/testbench.sv
// testbench for murmur3_32_stream_hash_core: byte-stream murmur3 x86_32 hashing
// random valid/ready stalls on both sides and seed rewrites between phases
// depends on mm3_pkg and murmur3_32_stream_hash_core
`timescale 1ns / 1ps

module testbench;

    import mm3_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned PHASE_ITEMS   = 130;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_SEED,
        STEP_DRAIN,
        STEP_PHASE
    } t_step_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              has_byte;
        logic              last;
    } t_stream_item;

    typedef struct {
        t_step_kind        kind;
        t_stream_item      item;
        logic [WORD_W-1:0] seed;
        int unsigned       send_idle;
        int unsigned       recv_stall;
    } t_plan_step;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [WORD_W-1:0] i_cfg_seed  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_has_byte  = 1'b0;
    logic              i_last      = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_hash;

    t_plan_step        byte_plan[$];
    logic [WORD_W-1:0] expected_hashes[$];

    // hash state mirrored from the block
    logic [WORD_W-1:0] seed_now;
    logic [WORD_W-1:0] running_hash;
    logic [WORD_W-1:0] partial_word;
    logic [WORD_W-1:0] msg_bytes;
    logic              msg_open;

    t_stream_item      cur_item;
    logic [WORD_W-1:0] cur_seed;
    logic              item_up;
    logic              seed_up;
    int unsigned       quiet_cycles;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       hash_errors    = 0;
    int unsigned       idle_run       = 0;
    int unsigned       planned_items  = 0;

    murmur3_32_stream_hash_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hash      (o_hash)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
        k = k * MIX_C1;
        k = {k[16:0], k[31:17]};
        k = k * MIX_C2;
        return k;
    endfunction

    function automatic void absorb_item(input t_stream_item it);
        logic [WORD_W-1:0] h;
        logic [1:0]        lane;
        if ((it.has_byte || it.last) && !msg_open) begin
            running_hash = seed_now;
            partial_word = '0;
            msg_bytes    = '0;
            msg_open     = 1'b1;
        end
        if (it.has_byte) begin
            lane         = msg_bytes[1:0];
            partial_word = partial_word | ({24'd0, it.data} << (8 * lane));
            msg_bytes    = msg_bytes + 1;
            if (lane == 2'd3) begin
                h            = running_hash ^ scramble_word(partial_word);
                h            = {h[18:0], h[31:19]};
                running_hash = h * 5 + MIX_ADD;
                partial_word = '0;
            end
        end
        if (it.last) begin
            h = running_hash ^ scramble_word(partial_word) ^ msg_bytes;
            h = h ^ (h >> 16);
            h = h * FIN_C1;
            h = h ^ (h >> 13);
            h = h * FIN_C2;
            h = h ^ (h >> 16);
            expected_hashes.push_back(h);
            msg_open = 1'b0;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_plan_step step;
        logic       moved;
        if (!i_rst_n) begin
            item_up      = 1'b0;
            seed_up      = 1'b0;
            quiet_cycles = 0;
            seed_now     = SEED_RESET;
            msg_open     = 1'b0;
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            moved = 1'b0;
            if (item_up && o_in_ready) begin
                absorb_item(cur_item);
                item_up = 1'b0;
                moved   = 1'b1;
            end
            if (seed_up && o_cfg_ready) begin
                seed_now = cur_seed;
                seed_up  = 1'b0;
                moved    = 1'b1;
            end
            if (moved || item_up || seed_up || expected_hashes.size() != 0)
                quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles++;

            if (!item_up && !seed_up && byte_plan.size() != 0) begin
                case (byte_plan[0].kind)
                    STEP_PHASE: begin
                        step           = byte_plan.pop_front();
                        send_idle_pct  = step.send_idle;
                        recv_stall_pct = step.recv_stall;
                    end
                    STEP_DRAIN: begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                            step = byte_plan.pop_front();
                    end
                    STEP_SEED: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            step        = byte_plan.pop_front();
                            cur_seed    = step.seed;
                            seed_up     = 1'b1;
                            i_cfg_seed <= step.seed;
                        end
                    end
                    default: begin
                        if ($urandom_range(99) >= send_idle_pct) begin
                            step         = byte_plan.pop_front();
                            cur_item     = step.item;
                            item_up      = 1'b1;
                            i_data_byte <= step.item.data;
                            i_has_byte  <= step.item.has_byte;
                            i_last      <= step.item.last;
                        end
                    end
                endcase
            end
            i_in_valid  <= item_up;
            i_cfg_valid <= seed_up;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hashes.size() == 0) begin
                    hash_errors++;
                    if (hash_errors <= MAX_REPORTS)
                        $display("unexpected hash transfer: got %08h", o_hash);
                end else begin
                    want = expected_hashes.pop_front();
                    if (o_hash !== want) begin
                        hash_errors++;
                        if (hash_errors <= MAX_REPORTS)
                            $display("hash mismatch: expected %08h got %08h", want, o_hash);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
                (o_out_valid && i_out_ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic void plan_item(input logic [BYTE_W-1:0] data,
                                      input logic has_byte, input logic last);
        t_plan_step step;
        step.kind          = STEP_ITEM;
        step.item.data     = data;
        step.item.has_byte = has_byte;
        step.item.last     = last;
        step.seed          = '0;
        step.send_idle     = 0;
        step.recv_stall    = 0;
        byte_plan.push_back(step);
        if (has_byte || last)
            planned_items++;
    endfunction

    function automatic void plan_control(input t_step_kind kind, input logic [WORD_W-1:0] seed,
                                         input int unsigned send_idle,
                                         input int unsigned recv_stall);
        t_plan_step step;
        step.kind       = kind;
        step.item       = '0;
        step.seed       = seed;
        step.send_idle  = send_idle;
        step.recv_stall = recv_stall;
        byte_plan.push_back(step);
    endfunction

    // one random message or a lone idle item, with occasional idle items and either terminator style
    function automatic void plan_message();
        int unsigned len;
        int unsigned kind;
        logic        split_end;
        kind = $urandom_range(99);
        if (kind < 8) begin
            plan_item(8'($urandom_range(255)), 1'b0, 1'b1);
            return;
        end
        if (kind < 14) begin
            plan_item(8'($urandom_range(255)), 1'b0, 1'b0);
            return;
        end
        len       = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        split_end = 1'($urandom_range(1));
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                plan_item(8'($urandom_range(255)), 1'b0, 1'b0);
            plan_item(8'($urandom_range(255)), 1'b1, !split_end && (i == len - 1));
        end
        if (split_end)
            plan_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endfunction

    function automatic void plan_random_phase(input int unsigned count);
        int unsigned goal;
        goal = planned_items + count;
        while (planned_items < goal)
            plan_message();
    endfunction

    initial begin
        // directed part under the reset seed
        plan_control(STEP_PHASE, '0, 33, 83);
        plan_item(8'h00, 1'b0, 1'b1);
        plan_item(8'hff, 1'b0, 1'b1);
        plan_item(8'h00, 1'b1, 1'b1);
        plan_item(8'hff, 1'b1, 1'b1);
        plan_item(8'hff, 1'b1, 1'b0);
        plan_item(8'hff, 1'b1, 1'b0);
        plan_item(8'hff, 1'b1, 1'b1);
        plan_item(8'h01, 1'b1, 1'b0);
        plan_item(8'h02, 1'b1, 1'b0);
        plan_item(8'h03, 1'b1, 1'b0);
        plan_item(8'h04, 1'b1, 1'b1);
        plan_item(8'haa, 1'b0, 1'b0);
        plan_item(8'h80, 1'b1, 1'b0);
        plan_item(8'h7f, 1'b1, 1'b0);
        plan_item(8'h55, 1'b0, 1'b0);
        plan_item(8'h55, 1'b1, 1'b0);
        plan_item(8'haa, 1'b1, 1'b0);
        plan_item(8'h5a, 1'b1, 1'b0);
        plan_item(8'hc3, 1'b0, 1'b1);
        plan_control(STEP_DRAIN, '0, 0, 0);

        plan_control(STEP_SEED, 32'h0000_0000, 0, 0);
        plan_item(8'h00, 1'b0, 1'b1);
        plan_random_phase(PHASE_ITEMS);
        plan_control(STEP_DRAIN, '0, 0, 0);
        plan_random_phase(8);

        plan_control(STEP_PHASE, '0, 83, 33);
        plan_control(STEP_SEED, 32'hffff_ffff, 0, 0);
        plan_item(8'h00, 1'b0, 1'b1);
        plan_random_phase(PHASE_ITEMS);

        plan_control(STEP_PHASE, '0, 0, 0);
        plan_control(STEP_SEED, $urandom, 0, 0);
        plan_random_phase(PHASE_ITEMS / 2);
        plan_control(STEP_SEED, $urandom, 0, 0);
        plan_random_phase(PHASE_ITEMS / 2);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_plan.size() != 0 || item_up || seed_up || expected_hashes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (hash_errors == 0 && expected_hashes.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: murmur3_32_stream_hash_core.f
hw/rtl/mm3_pkg.sv
hw/rtl/mm3_ctrl.sv
hw/rtl/mm3_dp.sv
hw/rtl/murmur3_32_stream_hash_core.sv
sim/testbench.sv
